[design/txu_pkg.sv]
`timescale 1ns / 1ps

package txu_pkg;

  // Queue depth default, register reset values and register indexes
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam logic [15:0] BIT_PERIOD_RESET = 16'd16;
  localparam logic [3:0] DATA_BITS_RESET = 4'd8;
  localparam logic [3:0] DATA_BITS_MAX = 4'd8;
  localparam logic [0:0] REG_BIT_PERIOD = 1'b0;
  localparam logic [0:0] REG_DATA_BITS = 1'b1;

  // Kind of an input item
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Phase of the character frame
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_START = 3'd1,
    PH_DATA = 3'd2,
    PH_STOP = 3'd3,
    PH_STOPEND = 3'd4
  } phase_t;

  // Classified item passed from the front end to the engine
  typedef struct packed {
    op_t op;
    logic [7:0] byte_value;
  } item_t;

endpackage

[design/buffered_uart_transmitter_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// cfg      | in        | cfg_valid/cfg_ready | cfg_index (0 bit period, 1 data bits), cfg_data
// in       | in        | in_tvalid/in_tready | in_tuser = mode, in_tdata = byte_value
// out      | out       | out_tvalid/out_tready | out_tdata = tx_level, busy_res, overflow, queued
//
// One item per clock cycle while the result side accepts it; each item's result is registered in
// the cycle after the item leaves the two-entry front queue.
// The engine updates the whole transmitter state as it takes each item.
// Reset (rst_n low, synchronous) empties both queues and idles the line high.
// A stalled result holds in the output register while the front queue takes up to two more items.

module buffered_uart_transmitter_unit #(
  parameter int QUEUE_DEPTH = txu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] mode: 0 push, 1 tick
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] tx_level, [1] busy_res, [2] overflow, [7:3] queued
);
  import txu_pkg::*;

  logic mid_valid;
  logic mid_ready;
  item_t mid_item;

  // Front end: accepts and classifies items
  txu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .mid_valid (mid_valid),
    .mid_ready (mid_ready),
    .mid_item  (mid_item)
  );

  // Engine: byte queue, frame sequencer and result register
  txu_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_item   (mid_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[design/txu_front.sv]
`timescale 1ns / 1ps

module txu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic           in_tuser,
  output logic           mid_valid,
  input  logic           mid_ready,
  output txu_pkg::item_t mid_item
);
  import txu_pkg::*;

  item_t slot_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic push, pop;
  item_t in_item;

  // Classify the incoming transfer
  always_comb begin
    in_item.op = in_tuser ? OP_TICK : OP_PUSH;
    in_item.byte_value = in_tdata;
  end

  assign in_tready = (fill_r != 2'd2);
  assign mid_valid = (fill_r != 2'd0);
  assign mid_item = slot_r[rd_ptr_r];
  assign push = in_tvalid && in_tready;
  assign pop = mid_valid && mid_ready;

  // Pointer and fill level of the two-entry queue
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'd2) else $error("front queue fill level out of range");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd2 && !pop |=> fill_r == 2'd2)
    else $error("front queue lost an item while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd0 |-> !pop) else $error("front queue popped while empty");

endmodule

[design/txu_engine.sv]
`timescale 1ns / 1ps

module txu_engine #(
  parameter int QUEUE_DEPTH = txu_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [0:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           mid_valid,
  output logic           mid_ready,
  input  txu_pkg::item_t mid_item,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata
);
  import txu_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  // Configuration registers
  logic [15:0] period_r;
  logic [3:0] dbits_r;

  // Transmitter state
  phase_t phase_r, phase_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic line_r, line_nxt;

  // Byte queue memory with registered read and write bypass
  logic [7:0] mem [QUEUE_DEPTH];
  logic [7:0] rd_mem_r;
  logic byp_r;
  logic [7:0] byp_data_r;
  logic [7:0] head_byte;

  logic out_valid_r;
  logic [7:0] out_data_r;

  logic go, is_tick, is_push, queue_full, push_ok, timer_zero, frame_go;
  logic ovf;
  logic [15:0] period_less_one;
  logic [3:0] eff_bits, bit_index_inc;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail, head_inc;

  assign cfg_ready = 1'b1;
  assign go = mid_valid && (!out_valid_r || out_tready);
  assign mid_ready = go;
  assign is_tick = go && (mid_item.op == OP_TICK);
  assign is_push = go && (mid_item.op == OP_PUSH);
  assign queue_full = (count_r == CW'(QUEUE_DEPTH));
  assign push_ok = is_push && !queue_full;
  assign ovf = is_push && queue_full;
  assign timer_zero = (timer_r == 16'd0);
  assign head_byte = byp_r ? byp_data_r : rd_mem_r;

  // Derived timing and framing values
  always_comb begin
    period_less_one = (period_r == 16'd0) ? 16'd0 : period_r - 16'd1;
    if (dbits_r == 4'd0) begin
      eff_bits = 4'd1;
    end else if (dbits_r > DATA_BITS_MAX) begin
      eff_bits = DATA_BITS_MAX;
    end else begin
      eff_bits = dbits_r;
    end
    bit_index_inc = bit_index_r + 4'd1;
    head_inc = (head_r == IW'(QUEUE_DEPTH - 1)) ? '0 : head_r + IW'(1);
    tail_sum = SW'(head_r) + SW'(count_r);
    tail = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                           : IW'(tail_sum);
  end

  // A new character starts when a start or stop-end bit expires with bytes waiting
  assign frame_go = is_tick && timer_zero && (count_r != '0) &&
                    (phase_r == PH_START || phase_r == PH_STOPEND);

  // Next frame phase
  always_comb begin
    phase_nxt = phase_r;
    if (push_ok && phase_r == PH_IDLE) begin
      phase_nxt = PH_START;
    end else if (is_tick && timer_zero) begin
      unique case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_START, PH_STOPEND: phase_nxt = frame_go ? PH_DATA : PH_IDLE;
        PH_DATA: phase_nxt = (bit_index_inc >= eff_bits) ? PH_STOP : PH_DATA;
        PH_STOP: phase_nxt = PH_STOPEND;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // Datapath updates for each phase
  always_comb begin
    head_nxt = head_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    bit_index_nxt = bit_index_r;
    timer_nxt = timer_r;
    line_nxt = line_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
      if (phase_r == PH_IDLE) begin
        timer_nxt = 16'd0;
      end
    end else if (is_tick && phase_r != PH_IDLE) begin
      if (!timer_zero) begin
        timer_nxt = timer_r - 16'd1;
      end else begin
        unique case (phase_r)
          PH_IDLE: line_nxt = line_r;
          PH_START, PH_STOPEND: begin
            if (frame_go) begin
              shift_nxt = head_byte;
              head_nxt = head_inc;
              count_nxt = count_r - CW'(1);
              line_nxt = 1'b0;
              bit_index_nxt = 4'd0;
              timer_nxt = period_less_one;
            end else begin
              line_nxt = 1'b1;
            end
          end
          PH_DATA: begin
            line_nxt = shift_r[bit_index_r[2:0]];
            bit_index_nxt = bit_index_inc;
            timer_nxt = period_less_one;
          end
          PH_STOP: begin
            line_nxt = 1'b1;
            timer_nxt = period_less_one;
          end
          default: line_nxt = 1'b1;
        endcase
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= BIT_PERIOD_RESET;
      dbits_r <= DATA_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BIT_PERIOD: period_r <= cfg_data;
        REG_DATA_BITS: dbits_r <= cfg_data[3:0];
        default: period_r <= period_r;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      head_r <= '0;
      count_r <= '0;
      shift_r <= 8'd0;
      bit_index_r <= 4'd0;
      timer_r <= 16'd0;
      line_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      bit_index_r <= bit_index_nxt;
      timer_r <= timer_nxt;
      line_r <= line_nxt;
    end
  end

  // Byte queue: write at the tail, read the next head into a register
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= mid_item.byte_value;
    end
    rd_mem_r <= mem[head_nxt];
    byp_r <= push_ok && (tail == head_nxt);
    byp_data_r <= mid_item.byte_value;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data_r <= {5'(count_nxt), ovf, (phase_nxt != PH_IDLE), line_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH)) else $error("byte queue count above depth");

  a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> line_r) else $error("line low while idle");

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bit_index_r < DATA_BITS_MAX)
    else $error("bit index past the data bits");

  a_tick_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> out_valid_r && !out_data_r[2])
    else $error("overflow flagged on a tick");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import txu_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT_RESULT = 600;
  localparam int RAND_PER_PHASE = 150;
  localparam int SLOW_TICKS = 24;

  // Result fields, laid out exactly as on out_tdata (tx_level in bit 0)
  typedef struct packed {
    logic [4:0] queued;
    logic overflow;
    logic busy;
    logic tx_level;
  } tx_status_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [0:0] sel;
    op_t op;
    logic [15:0] val;
    bit known;
    tx_status_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = REG_BIT_PERIOD;
  logic [15:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;

  buffered_uart_transmitter_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // Expected line status per accepted item, oldest first
  tx_status_t status_q[$];
  int failures = 0;
  int results_seen = 0;
  int cycle_count = 0;
  bit steady_send = 1'b0;

  // Directed stimulus table
  script_row_t script[$];

  // Own copy of the transmitter state and its two registers
  logic [7:0] fifo_mem [QDEPTH];
  int fifo_head = 0;
  int fifo_count = 0;
  logic [7:0] cur_char = '0;
  int bit_pos = 0;
  phase_t phase = PH_IDLE;
  int wait_ticks = 0;
  logic line_q = 1'b1;
  logic [15:0] reg_period = BIT_PERIOD_RESET;
  logic [3:0] reg_width = DATA_BITS_RESET;

  // A zero bit period behaves as one tick per bit.
  function automatic int period_m1();
    return (reg_period == 16'd0) ? 0 : int'(reg_period) - 1;
  endfunction

  // Character width is clamped to the range one to eight.
  function automatic int char_bits();
    if (reg_width == 4'd0) return 1;
    if (reg_width > DATA_BITS_MAX) return int'(DATA_BITS_MAX);
    return int'(reg_width);
  endfunction

  // Pops the next character and drives its start bit, or idles on an empty queue.
  function automatic void load_next_char();
    if (fifo_count == 0) begin
      phase = PH_IDLE;
      line_q = 1'b1;
      return;
    end
    cur_char = fifo_mem[fifo_head];
    fifo_head = (fifo_head + 1) % QDEPTH;
    fifo_count--;
    line_q = 1'b0;
    bit_pos = 0;
    wait_ticks = period_m1();
    phase = PH_DATA;
  endfunction

  // Applies one push or tick to the transmitter copy and returns the line status.
  function automatic tx_status_t line_after_item(op_t op, logic [7:0] val);
    tx_status_t r;
    r.overflow = 1'b0;
    if (op == OP_PUSH) begin
      if (fifo_count >= QDEPTH) begin
        r.overflow = 1'b1;
      end else begin
        fifo_mem[(fifo_head + fifo_count) % QDEPTH] = val;
        fifo_count++;
        if (phase == PH_IDLE) begin
          phase = PH_START;
          wait_ticks = 0;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (wait_ticks != 0) begin
        wait_ticks--;
      end else begin
        case (phase)
          PH_START: begin
            load_next_char();
          end
          PH_DATA: begin
            line_q = cur_char[bit_pos & 7];
            bit_pos = (bit_pos + 1) & 15;
            if (bit_pos >= char_bits()) phase = PH_STOP;
            wait_ticks = period_m1();
          end
          PH_STOP: begin
            line_q = 1'b1;
            wait_ticks = period_m1();
            phase = PH_STOPEND;
          end
          default: begin
            // End of the stop bit: the next character follows at once.
            if (fifo_count > 0) begin
              load_next_char();
            end else begin
              phase = PH_IDLE;
              line_q = 1'b1;
            end
          end
        endcase
      end
    end
    r.tx_level = line_q;
    r.busy = (phase != PH_IDLE);
    r.queued = 5'(fifo_count);
    return r;
  endfunction

  function automatic tx_status_t mk_status(logic tx, logic busy, logic ovf, int q);
    tx_status_t s;
    s.tx_level = tx;
    s.busy = busy;
    s.overflow = ovf;
    s.queued = 5'(q);
    return s;
  endfunction

  function automatic script_row_t item_row(op_t op, logic [7:0] val);
    script_row_t r;
    r.kind = ROW_ITEM;
    r.sel = REG_BIT_PERIOD;
    r.op = op;
    r.val = {8'h00, val};
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic script_row_t known_row(op_t op, logic [7:0] val, tx_status_t want);
    script_row_t r;
    r = item_row(op, val);
    r.known = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic script_row_t cfg_row(logic [0:0] sel, logic [15:0] val);
    script_row_t r;
    r = item_row(OP_TICK, 8'h00);
    r.kind = ROW_CFG;
    r.sel = sel;
    r.val = val;
    return r;
  endfunction

  // Appends one row to the end of the directed table.
  function automatic void append_row(script_row_t r);
    script.insert(script.size(), r);
  endfunction

  // Offers one item, with random gaps, and records its expected status once accepted.
  task automatic send_item(input op_t op, input logic [7:0] val, input bit known,
                           input tx_status_t want);
    tx_status_t p;
    while (!steady_send && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
    p = line_after_item(op, val);
    status_q.insert(status_q.size(), known ? want : p);
  endtask

  // Register writes happen only once every pending result has been drained.
  task automatic write_reg(input logic [0:0] sel, input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == REG_BIT_PERIOD) reg_period = val;
    else reg_width = val[3:0];
  endtask

  // Result side: checks each transfer and drives a random, sometimes held, ready.
  int hold_left = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin : result_side
    tx_status_t got;
    tx_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      results_seen++;
      if (status_q.size() == 0) begin
        $error("result %h arrived with nothing expected", out_tdata);
        failures++;
      end else begin
        want = status_q.pop_front();
        if (got.tx_level !== want.tx_level) begin
          $error("tx_level expected %0d got %0d", want.tx_level, got.tx_level);
          failures++;
        end
        if (got.busy !== want.busy) begin
          $error("busy_res expected %0d got %0d", want.busy, got.busy);
          failures++;
        end
        if (got.overflow !== want.overflow) begin
          $error("overflow expected %0d got %0d", want.overflow, got.overflow);
          failures++;
        end
        if (got.queued !== want.queued) begin
          $error("queued expected %0d got %0d", want.queued, got.queued);
          failures++;
        end
      end
    end
    // One long hold-off lets the block fill up and push back on its input.
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held_once && results_seen >= HOLD_AT_RESULT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (results_seen >= 300 && results_seen < 500) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 24);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[buffered_uart_transmitter_unit] ERROR");
      $finish;
    end
  end

  // Stimulus: directed script, random phases over several settings, slowest baud last.
  initial begin : stimulus
    script_row_t row;
    logic [15:0] periods [8];
    logic [3:0] widths [8];
    int push_pct;
    int sent_random;
    op_t op;

    periods = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd5, 16'd2, 16'd16};
    widths = '{4'd8, 4'd1, 4'd7, 4'd15, 4'd5, 4'd8, 4'd9, 4'd3};

    // Tick while idle, then a one-bit character at the fastest rate.
    append_row(known_row(OP_TICK, 8'hA5, mk_status(1'b1, 1'b0, 1'b0, 0)));
    append_row(cfg_row(REG_BIT_PERIOD, 16'd0));
    append_row(cfg_row(REG_DATA_BITS, 16'd0));
    append_row(known_row(OP_PUSH, 8'hFF, mk_status(1'b1, 1'b1, 1'b0, 1)));
    append_row(known_row(OP_TICK, 8'h00, mk_status(1'b0, 1'b1, 1'b0, 0)));
    append_row(known_row(OP_TICK, 8'hFF, mk_status(1'b1, 1'b1, 1'b0, 0)));
    append_row(known_row(OP_TICK, 8'h00, mk_status(1'b1, 1'b1, 1'b0, 0)));
    append_row(known_row(OP_TICK, 8'h00, mk_status(1'b1, 1'b0, 1'b0, 0)));
    // Fill the queue past its depth; the last push is dropped.
    append_row(cfg_row(REG_DATA_BITS, 16'd15));
    append_row(cfg_row(REG_BIT_PERIOD, 16'd3));
    for (int i = 0; i <= QDEPTH; i++) begin
      append_row(known_row(OP_PUSH, 8'((i * 8'h35) ^ (i[0] ? 8'hFF : 8'h00)),
                           mk_status(1'b1, 1'b1, i == QDEPTH,
                                     (i < QDEPTH) ? i + 1 : QDEPTH)));
    end
    append_row(item_row(OP_TICK, 8'h00));
    append_row(item_row(OP_PUSH, 8'h80));
    append_row(item_row(OP_TICK, 8'h7F));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) write_reg(row.sel, row.val);
      else send_item(row.op, row.val[7:0], row.known, row.want);
    end

    // Random phases; register changes often land in the middle of a character.
    sent_random = 0;
    push_pct = 10;
    foreach (periods[p]) begin
      write_reg(REG_BIT_PERIOD, periods[p]);
      write_reg(REG_DATA_BITS, {12'h000, widths[p]});
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(3))
            0: push_pct = 3;
            1: push_pct = 10;
            2: push_pct = 25;
            default: push_pct = 60;
          endcase
        end
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_TICK;
        steady_send = (sent_random >= 300 && sent_random < 500);
        send_item(op, 8'($urandom_range(255)), 1'b0, '0);
        sent_random++;
      end
    end
    steady_send = 1'b0;

    // Slowest bit period: the start bit begins and the wide timer counts down.
    write_reg(REG_BIT_PERIOD, 16'hFFFF);
    write_reg(REG_DATA_BITS, {12'h000, DATA_BITS_MAX});
    send_item(OP_PUSH, 8'($urandom_range(255)), 1'b0, '0);
    send_item(OP_PUSH, 8'($urandom_range(255)), 1'b0, '0);
    for (int n = 0; n < SLOW_TICKS; n++) begin
      send_item(OP_TICK, 8'($urandom_range(255)), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[buffered_uart_transmitter_unit] OK");
    end else begin
      $display("[buffered_uart_transmitter_unit] ERROR");
    end
    $finish;
  end

endmodule
